// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_P(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_P(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== hw/rtl/tbi_pkg.sv =====
// types, constants and the sine table of the turtle branch interpreter
`timescale 1ns / 1ps
`default_nettype none
package tbi_pkg;

  localparam int STACK_DEPTH  = 64;
  localparam int HEADING_BITS = 12;

  localparam int HEAD_W       = HEADING_BITS;
  localparam int HEAD_QUARTER = 1 << (HEADING_BITS - 2);
  localparam int HEAD_HALF    = 1 << (HEADING_BITS - 1);
  localparam int ROM_N        = HEAD_QUARTER + 1;
  localparam int ROM_AW       = HEADING_BITS - 1;

  localparam int SP_W   = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  localparam int STEP_W    = 26;
  localparam int TURN_W    = 12;
  localparam int COORD_W   = 16;
  localparam int POS_W     = 32;
  localparam int FRAC_W    = 16;
  localparam int TRIG_W    = 16;
  localparam int TRIG_FRAC = 15;
  localparam int PROD_W    = STEP_W + 1 + TRIG_W;
  localparam int DELTA_W   = PROD_W - TRIG_FRAC;
  localparam int CFG_W     = 26;
  localparam int SYM_W     = 8;
  localparam int KIND_W    = 2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  localparam logic [SYM_W-1:0] SYM_FWD   = 8'h46;  // F
  localparam logic [SYM_W-1:0] SYM_PUSH  = 8'h5B;  // [
  localparam logic [SYM_W-1:0] SYM_POP   = 8'h5D;  // ]
  localparam logic [SYM_W-1:0] SYM_LEFT  = 8'h2B;  // +
  localparam logic [SYM_W-1:0] SYM_RIGHT = 8'h2D;  // -

  typedef enum logic [1:0] {
    CFG_STEP    = 2'd0,
    CFG_TURN    = 2'd1,
    CFG_START_X = 2'd2,
    CFG_START_Y = 2'd3
  } cfg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_LINE = 2'd0,
    KIND_MOVE = 2'd1,
    KIND_OVF  = 2'd2,
    KIND_UNF  = 2'd3
  } kind_t;

  // command passed through the queue
  typedef enum logic [2:0] {
    OP_BEGIN = 3'd0,
    OP_FWD   = 3'd1,
    OP_PUSH  = 3'd2,
    OP_POP   = 3'd3,
    OP_LEFT  = 3'd4,
    OP_RIGHT = 3'd5
  } op_t;

  // resolved action flowing down the back pipeline
  typedef enum logic [2:0] {
    EX_NONE  = 3'd0,
    EX_LINE  = 3'd1,
    EX_BEGIN = 3'd2,
    EX_PUSH  = 3'd3,
    EX_POP   = 3'd4,
    EX_OVF   = 3'd5,
    EX_UNF   = 3'd6
  } ex_t;

  typedef struct packed {
    logic [STEP_W-1:0]         step_length;
    logic [TURN_W-1:0]         turn_angle;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
  } cfg_t;

  typedef struct packed {
    logic              neg;
    logic [ROM_AW-1:0] idx;
  } rom_sel_t;

  typedef logic signed [TRIG_W-1:0] rom_arr_t [ROM_N];

  // (a*b) >> 60
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // quarter wave of round(32767*sin), taylor series in q60
  function automatic rom_arr_t build_sine_rom();
    rom_arr_t    rom;
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] s;
    logic        sub;
    int          n;
    for (int k = 0; k < ROM_N; k++) begin
      x = (PI_Q60 / 64'(HEAD_HALF)) * 64'(k)
        + ((PI_Q60 % 64'(HEAD_HALF)) * 64'(k)) / 64'(HEAD_HALF);
      t = x;
      s = x;
      sub = 1'b1;
      for (n = 3; n <= 27; n += 2) begin
        t = mul_q60(mul_q60(t, x), x) / 64'((n - 1) * n);
        s = sub ? s - t : s + t;
        sub = !sub;
      end
      rom[k] = TRIG_W'(((s >> 20) * 64'd32767 + (64'd1 << 39)) >> 40);
    end
    return rom;
  endfunction

  localparam rom_arr_t SINE_ROM = build_sine_rom();

  // fold a heading onto the quarter-wave table
  function automatic rom_sel_t rom_sel(input logic [HEAD_W-1:0] h);
    rom_sel_t          r;
    logic [HEAD_W-1:0] q;
    r.neg = h[HEAD_W-1];
    q = {1'b0, h[HEAD_W-2:0]};
    if (q > HEAD_W'(HEAD_QUARTER)) begin
      q = HEAD_W'(HEAD_HALF) - q;
    end
    r.idx = q[ROM_AW-1:0];
    return r;
  endfunction

  // floor(pos + 0.5), low bits
  function automatic logic [COORD_W-1:0] round_pos(input logic [POS_W-1:0] p);
    return p[POS_W-1:FRAC_W] + COORD_W'(p[FRAC_W-1]);
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tbi_front.sv =====
// front end: accepts beats, decodes symbols, drops the ones with no effect
`timescale 1ns / 1ps
`default_nettype none
module tbi_front import tbi_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [SYM_W-1:0] in_tdata,   // symbol
  input  logic             in_tuser,   // begin_req
  input  logic             q_ready,
  output logic             q_push,
  output op_t              q_op
);

  logic keep;
  logic acc_seen_r;

  always_comb begin
    keep = 1'b1;
    q_op = OP_BEGIN;
    if (in_tuser) begin
      q_op = OP_BEGIN;
    end else begin
      unique case (in_tdata)
        SYM_FWD:   q_op = OP_FWD;
        SYM_PUSH:  q_op = OP_PUSH;
        SYM_POP:   q_op = OP_POP;
        SYM_LEFT:  q_op = OP_LEFT;
        SYM_RIGHT: q_op = OP_RIGHT;
        default:   keep = 1'b0;
      endcase
    end
  end

  assign in_tready = q_ready;
  assign q_push    = in_tvalid && q_ready && keep;

  // tracks that something was accepted since reset, used by the check below
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_seen_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      acc_seen_r <= 1'b1;
    end
  end

  `include "assert_macros.svh"
  `ASSERT_NEVER(a_push_no_accept, q_push && !(in_tvalid && in_tready), "push without accept")
  `ASSERT_P(a_seen_sticky, acc_seen_r |=> acc_seen_r, "accept flag dropped")

endmodule
`default_nettype wire

// ===== hw/rtl/tbi_queue.sv =====
// short command queue between front and back
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tbi_queue import tbi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  output logic push_ready,
  output logic pop_valid,
  output op_t  pop_op,
  input  logic pop_take
);

  op_t               ent_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign push_ready = cnt_r != QCNT_W'(QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_op     = ent_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop_take && pop_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_op;
    end
  end

  `ASSERT_NEVER(a_cnt_range, cnt_r > QCNT_W'(QDEPTH), "queue count beyond depth")

endmodule
`default_nettype wire

// ===== hw/rtl/tbi_back.sv =====
// back end: turtle state, branch stacks, step pipeline and output register
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tbi_back import tbi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  logic                 q_valid,
  input  op_t                  q_op,
  output logic                 q_take,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [2*COORD_W-1:0] out_tdata,
  output logic [KIND_W-1:0]    out_tuser
);

  logic advance;

  // issue stage state
  logic [HEAD_W-1:0] heading_r, heading_nxt;
  logic [SP_W-1:0]   sp_r, sp_nxt, sp_dec;
  logic              pop_wait_r, pop_wait_nxt;
  logic [HEAD_W-1:0] hrd_r;
  logic [HEAD_W-1:0] hmem [STACK_DEPTH];
  logic [HEAD_W-1:0] turn_h;
  ex_t               ex_c;
  logic [ADDR_W-1:0] addr_c;
  logic              hpush, hpop;
  rom_sel_t          sel_sin, sel_cos;

  // multiply stage
  ex_t                       s2_ex_r;
  logic [ADDR_W-1:0]         s2_addr_r;
  logic signed [TRIG_W-1:0]  s2_sin_r, s2_cos_r;
  logic                      s2_sin_neg_r, s2_cos_neg_r;
  logic signed [TRIG_W-1:0]  trig_x, trig_y;
  logic signed [PROD_W-1:0]  prod_x, prod_y;
  logic                      fwd_c;

  // update stage
  ex_t                       s3_ex_r;
  logic signed [DELTA_W-1:0] s3_dx_r, s3_dy_r;
  logic [ADDR_W-1:0]         s3_addr_r;
  logic                      s3_fwd_r;
  logic [2*POS_W-1:0]        s3_rd_r;
  logic [2*POS_W-1:0]        pmem [STACK_DEPTH];
  logic [POS_W-1:0]          pen_x_r, pen_x_nxt, pen_y_r, pen_y_nxt;
  logic                      emit;
  kind_t                     kind_c;

  // output register
  logic               out_valid_r;
  kind_t              out_kind_r;
  logic [COORD_W-1:0] out_x_r, out_y_r;

  assign advance = !out_valid_r || out_tready;
  assign q_take  = advance && !pop_wait_r && q_valid;
  assign turn_h  = HEAD_W'(cfg.turn_angle);
  assign sp_dec  = sp_r - 1'b1;

  // ---------------- issue: heading, stack pointer, heading stack, rom address
  always_comb begin
    heading_nxt  = heading_r;
    sp_nxt       = sp_r;
    pop_wait_nxt = pop_wait_r;
    ex_c         = EX_NONE;
    addr_c       = '0;
    hpush        = 1'b0;
    hpop         = 1'b0;
    if (pop_wait_r) begin
      heading_nxt  = hrd_r;
      pop_wait_nxt = 1'b0;
    end else if (q_valid) begin
      unique case (q_op)
        OP_BEGIN: begin
          heading_nxt = HEAD_W'(HEAD_QUARTER);
          sp_nxt      = '0;
          ex_c        = EX_BEGIN;
        end
        OP_FWD: begin
          ex_c = EX_LINE;
        end
        OP_PUSH: begin
          if (sp_r >= SP_W'(STACK_DEPTH)) begin
            ex_c = EX_OVF;
          end else begin
            ex_c   = EX_PUSH;
            addr_c = sp_r[ADDR_W-1:0];
            sp_nxt = sp_r + 1'b1;
            hpush  = 1'b1;
          end
        end
        OP_POP: begin
          if (sp_r == '0) begin
            ex_c = EX_UNF;
          end else begin
            ex_c         = EX_POP;
            addr_c       = sp_dec[ADDR_W-1:0];
            sp_nxt       = sp_dec;
            hpop         = 1'b1;
            pop_wait_nxt = 1'b1;
          end
        end
        OP_LEFT:  heading_nxt = heading_r + turn_h;
        OP_RIGHT: heading_nxt = heading_r - turn_h;
        default:  ex_c = EX_NONE;
      endcase
    end
  end

  assign sel_sin = rom_sel(heading_r);
  assign sel_cos = rom_sel(heading_r + HEAD_W'(HEAD_QUARTER));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heading_r  <= HEAD_W'(HEAD_QUARTER);
      sp_r       <= '0;
      pop_wait_r <= 1'b0;
      s2_ex_r    <= EX_NONE;
    end else if (advance) begin
      heading_r  <= heading_nxt;
      sp_r       <= sp_nxt;
      pop_wait_r <= pop_wait_nxt;
      s2_ex_r    <= ex_c;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_addr_r    <= addr_c;
      s2_sin_r     <= SINE_ROM[sel_sin.idx];
      s2_cos_r     <= SINE_ROM[sel_cos.idx];
      s2_sin_neg_r <= sel_sin.neg;
      s2_cos_neg_r <= sel_cos.neg;
    end
  end

  // heading stack
  always_ff @(posedge clk) begin
    if (advance && hpush) begin
      hmem[addr_c] <= heading_r;
    end
    if (advance && hpop) begin
      hrd_r <= hmem[addr_c];
    end
  end

  // ---------------- multiply: step length times cosine and sine
  assign trig_x = s2_cos_neg_r ? -s2_cos_r : s2_cos_r;
  assign trig_y = s2_sin_neg_r ? -s2_sin_r : s2_sin_r;
  assign prod_x = $signed({1'b0, cfg.step_length}) * trig_x;
  assign prod_y = $signed({1'b0, cfg.step_length}) * trig_y;

  // a pop right behind its push finds the pen it saved still in place
  assign fwd_c = (s3_ex_r == EX_PUSH) && (s3_addr_r == s2_addr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ex_r <= EX_NONE;
    end else if (advance) begin
      s3_ex_r <= s2_ex_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_dx_r   <= prod_x[PROD_W-1:TRIG_FRAC];
      s3_dy_r   <= prod_y[PROD_W-1:TRIG_FRAC];
      s3_addr_r <= s2_addr_r;
      s3_fwd_r  <= fwd_c;
    end
  end

  // position stack
  always_ff @(posedge clk) begin
    if (advance && (s3_ex_r == EX_PUSH)) begin
      pmem[s3_addr_r] <= {pen_x_r, pen_y_r};
    end
    if (advance && (s2_ex_r == EX_POP)) begin
      s3_rd_r <= pmem[s2_addr_r];
    end
  end

  // ---------------- update: pen position and result
  always_comb begin
    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    emit      = 1'b0;
    kind_c    = KIND_LINE;
    unique case (s3_ex_r)
      EX_LINE: begin
        pen_x_nxt = pen_x_r + {{(POS_W-DELTA_W){s3_dx_r[DELTA_W-1]}}, s3_dx_r};
        pen_y_nxt = pen_y_r + {{(POS_W-DELTA_W){s3_dy_r[DELTA_W-1]}}, s3_dy_r};
        emit      = 1'b1;
        kind_c    = KIND_LINE;
      end
      EX_BEGIN: begin
        pen_x_nxt = {cfg.start_x, {FRAC_W{1'b0}}};
        pen_y_nxt = {cfg.start_y, {FRAC_W{1'b0}}};
        emit      = 1'b1;
        kind_c    = KIND_MOVE;
      end
      EX_POP: begin
        if (!s3_fwd_r) begin
          pen_x_nxt = s3_rd_r[2*POS_W-1:POS_W];
          pen_y_nxt = s3_rd_r[POS_W-1:0];
        end
        emit   = 1'b1;
        kind_c = KIND_MOVE;
      end
      EX_OVF: begin
        emit   = 1'b1;
        kind_c = KIND_OVF;
      end
      EX_UNF: begin
        emit   = 1'b1;
        kind_c = KIND_UNF;
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r     <= '0;
      pen_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      pen_x_r     <= pen_x_nxt;
      pen_y_r     <= pen_y_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_kind_r <= kind_c;
      out_x_r    <= round_pos(pen_x_nxt);
      out_y_r    <= round_pos(pen_y_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_y_r, out_x_r};
  assign out_tuser  = out_kind_r;

  `ASSERT_NEVER(a_sp_range, sp_r > SP_W'(STACK_DEPTH), "stack pointer beyond depth")
  `ASSERT_P(a_pop_wait, pop_wait_r |-> (s2_ex_r == EX_POP), "heading restore without pop")
  `ASSERT_P(a_stall_hold, !advance |=> ($stable(s3_ex_r) && $stable(pen_x_r)), "stage moved on stall")

endmodule
`default_nettype wire

// ===== hw/rtl/turtle_branch_interpreter_top.sv =====
// top level of the turtle branch interpreter: config registers, front, queue, back
//
//  channel  dir  beat fields (low bit first)               handshake
//  in_      in   tdata: symbol[7:0]; tuser: begin_req      in_tvalid / in_tready
//  out_     out  tdata: x_out[15:0], y_out[15:0];          out_tvalid / out_tready
//                tuser: kind[1:0]
//  cfg_     in   cfg_index selects register, cfg_data      cfg_we, no wait
//
//  one input beat per cycle while the queue has room; a ']' that restores a branch
//  holds the issue stage while the saved heading comes out of the stack memory
//  after its beat is accepted, a result passes the queue, issue, multiply and
//  pen update stages into the output register
//  rst_n is synchronous: turtle at origin heading up, empty stack and queue,
//  registers at their defaults; the stack memories are not cleared
//  a stalled output stops the back pipeline; the four-entry queue keeps
//  taking beats until it fills
`timescale 1ns / 1ps
`default_nettype none
module turtle_branch_interpreter_top import tbi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [SYM_W-1:0]     in_tdata,    // symbol[7:0]
  input  logic                 in_tuser,    // begin_req
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [2*COORD_W-1:0] out_tdata,   // x_out[15:0], y_out[31:16]
  output logic [KIND_W-1:0]    out_tuser,   // kind[1:0]
  // register writes
  input  logic                 cfg_we,
  input  cfg_idx_t             cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t cfg_r;
  logic q_ready;
  logic q_push;
  op_t  q_push_op;
  logic q_valid;
  op_t  q_op;
  logic q_take;

  // configuration registers, written by the user only while idle; not enforced
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_length <= STEP_W'(655360);
      cfg_r.turn_angle  <= TURN_W'(455);
      cfg_r.start_x     <= '0;
      cfg_r.start_y     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP:    cfg_r.step_length <= cfg_data[STEP_W-1:0];
        CFG_TURN:    cfg_r.turn_angle  <= cfg_data[TURN_W-1:0];
        CFG_START_X: cfg_r.start_x     <= cfg_data[COORD_W-1:0];
        CFG_START_Y: cfg_r.start_y     <= cfg_data[COORD_W-1:0];
        default:     cfg_r.start_y     <= cfg_r.start_y;
      endcase
    end
  end

  // decode symbols; ignored ones are accepted and dropped here
  tbi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_op      (q_push_op)
  );

  // decouples input acceptance from output backpressure
  tbi_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (q_push_op),
    .push_ready (q_ready),
    .pop_valid  (q_valid),
    .pop_op     (q_op),
    .pop_take   (q_take)
  );

  // turtle state, branch stacks, step arithmetic and result register
  tbi_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_op       (q_op),
    .q_take     (q_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

// ===== dv/tb_turtle_branch_interpreter_top.sv =====
// testbench for the turtle branch interpreter: directed symbol table, then random symbol streams and a deep nesting run
`timescale 1ns / 1ps
module tb_turtle_branch_interpreter_top;
  import tbi_pkg::*;

  localparam int  CYCLE_LIMIT = 400000;
  localparam int  SETTLE      = 12;     // edges to let an ignored symbol leave the pipe
  localparam int  LONG_HOLD   = 120;    // receiver hold-off that fills the input queue
  localparam int  MAX_GAP     = 6;
  localparam int  DIR_ROWS    = 21;
  localparam real FULL_TURN   = 2.0 * 3.14159265358979323846;

  // one pen event as it leaves the block
  typedef struct packed {
    kind_t              kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } pen_event_t;

  // one row of the directed table; typed rows carry their own expected event
  typedef struct packed {
    logic             beg;
    logic [SYM_W-1:0] sym;
    logic             typed;
    pen_event_t       ev;
  } stim_row_t;

  localparam pen_event_t NO_EVENT = '{KIND_LINE, 16'd0, 16'd0};

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [SYM_W-1:0]     in_tdata;    // symbol[7:0]
  logic                 in_tuser;    // begin_req
  logic                 out_tvalid;
  logic                 out_tready;
  logic [2*COORD_W-1:0] out_tdata;   // x_out[15:0], y_out[31:16]
  logic [KIND_W-1:0]    out_tuser;   // kind[1:0]
  logic                 cfg_we;
  cfg_idx_t             cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  turtle_branch_interpreter_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // shadow registers
  logic [STEP_W-1:0]  step_len;
  logic [TURN_W-1:0]  turn_step;
  logic [COORD_W-1:0] home_x;
  logic [COORD_W-1:0] home_y;

  // shadow turtle and branch stack
  logic [POS_W-1:0]  pen_x;
  logic [POS_W-1:0]  pen_y;
  logic [HEAD_W-1:0] heading;
  int                branch_depth;
  logic [POS_W-1:0]  saved_x    [STACK_DEPTH];
  logic [POS_W-1:0]  saved_y    [STACK_DEPTH];
  logic [HEAD_W-1:0] saved_head [STACK_DEPTH];

  int         sine_tab [HEAD_QUARTER+1];   // quarter wave, q1.15
  pen_event_t pen_events_q [$];            // pen events still to come out
  stim_row_t  dir_rows [DIR_ROWS];
  int         errors;
  int         cycle_count;
  bit         sender_burst;
  bit         sink_burst;
  bit         long_hold_req;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // sine of a heading, folded onto the quarter-wave table
  function automatic int trig_of(input logic [HEAD_W-1:0] h);
    logic [HEAD_W-1:0] q;
    bit                neg;
    q   = h;
    neg = 1'b0;
    if (q >= HEAD_W'(HEAD_HALF)) begin
      neg = 1'b1;
      q   = q - HEAD_W'(HEAD_HALF);
    end
    if (q > HEAD_W'(HEAD_QUARTER)) begin
      q = HEAD_W'(HEAD_HALF) - q;
    end
    return neg ? -sine_tab[q] : sine_tab[q];
  endfunction

  // floor(len * trig / 2^15), wrapped to the position width
  function automatic logic [POS_W-1:0] step_delta(input logic [STEP_W-1:0] len, input int trig);
    longint prod;
    prod = longint'(len) * longint'(trig);
    return POS_W'(prod >>> TRIG_FRAC);
  endfunction

  // floor(pos + 0.5), low pixel bits
  function automatic logic [COORD_W-1:0] pixel_of(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] r;
    r = p + 32'h0000_8000;
    return r[POS_W-1:FRAC_W];
  endfunction

  // advance the shadow turtle by one symbol, return the pen event if any
  task automatic turtle_interpret(input logic beg, input logic [SYM_W-1:0] sym,
                                  output bit emits, output pen_event_t ev);
    emits   = 1'b1;
    ev.kind = KIND_LINE;
    if (beg) begin
      pen_x        = {home_x, 16'h0000};
      pen_y        = {home_y, 16'h0000};
      heading      = HEAD_W'(HEAD_QUARTER);
      branch_depth = 0;
      ev.kind      = KIND_MOVE;
    end else begin
      case (sym)
        SYM_FWD: begin
          pen_x = pen_x + step_delta(step_len, trig_of(heading + HEAD_W'(HEAD_QUARTER)));
          pen_y = pen_y + step_delta(step_len, trig_of(heading));
        end
        SYM_PUSH: begin
          if (branch_depth >= STACK_DEPTH) begin
            ev.kind = KIND_OVF;
          end else begin
            saved_x[branch_depth]    = pen_x;
            saved_y[branch_depth]    = pen_y;
            saved_head[branch_depth] = heading;
            branch_depth++;
            emits = 1'b0;
          end
        end
        SYM_POP: begin
          if (branch_depth == 0) begin
            ev.kind = KIND_UNF;
          end else begin
            branch_depth--;
            pen_x   = saved_x[branch_depth];
            pen_y   = saved_y[branch_depth];
            heading = saved_head[branch_depth];
            ev.kind = KIND_MOVE;
          end
        end
        SYM_LEFT: begin
          heading = heading + turn_step;
          emits   = 1'b0;
        end
        SYM_RIGHT: begin
          heading = heading - turn_step;
          emits   = 1'b0;
        end
        default: begin
          emits = 1'b0;
        end
      endcase
    end
    ev.x = pixel_of(pen_x);
    ev.y = pixel_of(pen_y);
  endtask

  // offer one input beat after a random gap and wait until it is taken
  task automatic send_beat(input logic beg, input logic [SYM_W-1:0] sym);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sym;
    in_tuser  <= beg;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic feed_symbol(input logic beg, input logic [SYM_W-1:0] sym);
    bit         emits;
    pen_event_t ev;
    send_beat(beg, sym);
    turtle_interpret(beg, sym, emits, ev);
    if (emits) begin
      pen_events_q.push_back(ev);
    end
  endtask

  // stop offering, wait for every pending event, then let the pipe go quiet
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pen_events_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // write all four registers on consecutive edges while the block is idle
  task automatic set_config(input logic [STEP_W-1:0] stp, input logic [TURN_W-1:0] trn,
                            input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STEP;
    cfg_data  <= CFG_W'(stp);
    @(posedge clk);
    cfg_index <= CFG_TURN;
    cfg_data  <= CFG_W'(trn);
    @(posedge clk);
    cfg_index <= CFG_START_X;
    cfg_data  <= CFG_W'(sx);
    @(posedge clk);
    cfg_index <= CFG_START_Y;
    cfg_data  <= CFG_W'(sy);
    @(posedge clk);
    cfg_we    <= 1'b0;
    step_len  = stp;
    turn_step = trn;
    home_x    = sx;
    home_y    = sy;
  endtask

  // mostly well-nested drawing strings, some broken nesting and noise bytes
  task automatic random_item(output logic beg, output logic [SYM_W-1:0] sym);
    int r;
    bit tidy;
    tidy = ($urandom_range(0, 99) < 85);
    r    = $urandom_range(0, 99);
    beg  = 1'b0;
    sym  = SYM_FWD;
    if (r < 3) begin
      beg = 1'b1;
      sym = SYM_W'($urandom_range(0, 255));
    end else if (r < 38) begin
      sym = SYM_FWD;
    end else if (r < 50) begin
      sym = SYM_LEFT;
    end else if (r < 62) begin
      sym = SYM_RIGHT;
    end else if (r < 76) begin
      sym = (tidy && branch_depth >= STACK_DEPTH - 4) ? SYM_POP : SYM_PUSH;
    end else if (r < 90) begin
      sym = (tidy && branch_depth == 0) ? SYM_PUSH : SYM_POP;
    end else begin
      sym = SYM_W'($urandom_range(0, 255));
    end
  endtask

  task automatic run_random(input int n, input bit with_hold);
    logic             beg;
    logic [SYM_W-1:0] sym;
    for (int i = 0; i < n; i++) begin
      // back-to-back beats into a stalled output so the queue fills up
      if (with_hold && i == n / 3) begin
        long_hold_req = 1'b1;
        sender_burst  = 1'b1;
      end
      if (!(with_hold && i >= n / 3 && i < n / 3 + 50) && $urandom_range(0, 59) == 0) begin
        sender_burst = !sender_burst;
      end
      random_item(beg, sym);
      feed_symbol(beg, sym);
    end
    sender_burst = 1'b0;
  endtask

  // nest past the stack depth to hit overflow, then unwind past empty for underflow
  task automatic deep_branch();
    feed_symbol(1'b1, 8'h00);
    repeat (STACK_DEPTH + 3) begin
      feed_symbol(1'b0, SYM_PUSH);
      if ($urandom_range(0, 1) == 1) begin
        feed_symbol(1'b0, SYM_LEFT);
      end
      feed_symbol(1'b0, SYM_FWD);
    end
    repeat (STACK_DEPTH + 3) feed_symbol(1'b0, SYM_POP);
  endtask

  task automatic random_config();
    logic [STEP_W-1:0] stp;
    logic [TURN_W-1:0] trn;
    stp = ($urandom_range(0, 3) == 0) ? STEP_W'($urandom) : STEP_W'($urandom_range(0, 2000000));
    trn = ($urandom_range(0, 4) == 0) ? TURN_W'(HEAD_QUARTER) : TURN_W'($urandom_range(0, 4095));
    set_config(stp, trn, COORD_W'($urandom_range(0, 65535)), COORD_W'($urandom_range(0, 65535)));
  endtask

  // compare one accepted output beat with the oldest pending event
  task automatic check_pen_event();
    pen_event_t want;
    if (pen_events_q.size() == 0) begin
      $display("%0t unexpected beat: kind %0d x %0d y %0d", $time, out_tuser,
               $signed(out_tdata[15:0]), $signed(out_tdata[31:16]));
      errors++;
    end else begin
      want = pen_events_q.pop_front();
      if (out_tuser !== want.kind) begin
        $display("%0t kind mismatch: expected %0d actual %0d", $time, want.kind, out_tuser);
        errors++;
      end
      if (out_tdata[15:0] !== want.x) begin
        $display("%0t x mismatch: expected %0d actual %0d", $time,
                 $signed(want.x), $signed(out_tdata[15:0]));
        errors++;
      end
      if (out_tdata[31:16] !== want.y) begin
        $display("%0t y mismatch: expected %0d actual %0d", $time,
                 $signed(want.y), $signed(out_tdata[31:16]));
        errors++;
      end
    end
  endtask

  // result side: random ready gaps, bursts with ready held high, long hold-offs on request
  initial begin : result_sink
    int gap;
    out_tready <= 1'b0;
    sink_burst = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        gap = LONG_HOLD;
      end else begin
        gap = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      check_pen_event();
      if ($urandom_range(0, 59) == 0) begin
        sink_burst = !sink_burst;
      end
    end
  end

  // hard stop if the block hangs
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    bit         emits;
    pen_event_t ev;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_STEP;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    errors        = 0;
    sender_burst  = 1'b0;
    long_hold_req = 1'b0;

    // round(32767 * sin) over a quarter turn
    for (int k = 0; k <= HEAD_QUARTER; k++) begin
      sine_tab[k] = $rtoi(32767.0 * $sin(FULL_TURN * $itor(k) / $itor(1 << HEAD_W)) + 0.5);
    end

    // shadow state after reset
    step_len     = 26'd655360;
    turn_step    = 12'd455;
    home_x       = '0;
    home_y       = '0;
    pen_x        = '0;
    pen_y        = '0;
    heading      = HEAD_W'(HEAD_QUARTER);
    branch_depth = 0;

    // default registers: 10 px step straight up from the origin
    dir_rows[0]  = '{1'b0, SYM_POP,   1'b1, '{KIND_UNF,  16'd0, 16'd0}};  // pop on empty
    dir_rows[1]  = '{1'b0, SYM_PUSH,  1'b0, NO_EVENT};
    dir_rows[2]  = '{1'b1, SYM_FWD,   1'b1, '{KIND_MOVE, 16'd0, 16'd0}};  // begin, symbol ignored
    dir_rows[3]  = '{1'b0, SYM_POP,   1'b1, '{KIND_UNF,  16'd0, 16'd0}};  // begin emptied stack
    dir_rows[4]  = '{1'b0, SYM_FWD,   1'b1, '{KIND_LINE, 16'd0, 16'd10}};
    dir_rows[5]  = '{1'b0, SYM_PUSH,  1'b0, NO_EVENT};
    dir_rows[6]  = '{1'b0, SYM_LEFT,  1'b0, NO_EVENT};
    dir_rows[7]  = '{1'b0, SYM_FWD,   1'b0, NO_EVENT};
    dir_rows[8]  = '{1'b0, SYM_RIGHT, 1'b0, NO_EVENT};
    dir_rows[9]  = '{1'b0, SYM_RIGHT, 1'b0, NO_EVENT};
    dir_rows[10] = '{1'b0, SYM_FWD,   1'b0, NO_EVENT};
    dir_rows[11] = '{1'b0, SYM_POP,   1'b1, '{KIND_MOVE, 16'd0, 16'd10}}; // back to branch point
    dir_rows[12] = '{1'b0, SYM_FWD,   1'b1, '{KIND_LINE, 16'd0, 16'd20}}; // heading restored
    dir_rows[13] = '{1'b0, 8'h00,     1'b0, NO_EVENT};
    dir_rows[14] = '{1'b0, 8'hFF,     1'b0, NO_EVENT};
    dir_rows[15] = '{1'b0, 8'h41,     1'b0, NO_EVENT};
    dir_rows[16] = '{1'b0, SYM_LEFT,  1'b0, NO_EVENT};
    dir_rows[17] = '{1'b0, SYM_FWD,   1'b0, NO_EVENT};
    dir_rows[18] = '{1'b1, 8'h00,     1'b1, '{KIND_MOVE, 16'd0, 16'd0}};
    dir_rows[19] = '{1'b1, 8'hFF,     1'b1, '{KIND_MOVE, 16'd0, 16'd0}};
    dir_rows[20] = '{1'b0, SYM_POP,   1'b1, '{KIND_UNF,  16'd0, 16'd0}};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed part straight out of reset
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_beat(dir_rows[i].beg, dir_rows[i].sym);
      turtle_interpret(dir_rows[i].beg, dir_rows[i].sym, emits, ev);
      if (dir_rows[i].typed) begin
        pen_events_q.push_back(dir_rows[i].ev);
      end else if (emits) begin
        pen_events_q.push_back(ev);
      end
    end

    // largest step and turn, start in opposite corners; positions wrap quickly
    set_config(26'h3FF_FFFF, 12'hFFF, 16'h8000, 16'h7FFF);
    run_random(250, 1'b1);

    // zero step and zero turn
    set_config(26'd0, 12'd0, 16'h7FFF, 16'h8000);
    run_random(120, 1'b0);

    // back to the defaults, full stack
    set_config(26'd655360, 12'd455, 16'd0, 16'd0);
    deep_branch();
    run_random(150, 1'b0);

    for (int p = 0; p < 6; p++) begin
      random_config();
      run_random(170, p == 3);
    end

    drain_results();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
